// ----- design/stbs_pkg.sv -----
// Shared constants and types for the sorted table binary search block.
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;

  // Fixed field widths of the ports
  localparam int IN_KEY_W = 32;
  localparam int IN_IDX_W = 10;
  localparam int POS_W    = 10;
  localparam int CFG_W    = 11;

  // Derived widths
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } result_t;

endpackage

// ----- design/stbs_key_ram.sv -----
// Key table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module stbs_key_ram (
  input  logic             clk,
  input  logic             wr_en,
  input  stbs_pkg::addr_t  wr_addr,
  input  stbs_pkg::key_t   wr_data,
  input  stbs_pkg::rd_req_t rd_req,
  output stbs_pkg::key_t   rd_data
);
  import stbs_pkg::*;

  key_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data between requests
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

// ----- design/stbs_search.sv -----
// Lower-bound search sequencer; all probes share one ordering compare and one table read port.
`timescale 1ns / 1ps
module stbs_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  stbs_pkg::key_t     key,
  input  stbs_pkg::cnt_t     n_used,
  output logic               idle,
  output stbs_pkg::rd_req_t  rd_req,
  input  stbs_pkg::key_t     rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output stbs_pkg::result_t  res
);
  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0] state_r, state_nxt;
  cnt_t       lo_r, lo_nxt;
  cnt_t       hi_r, hi_nxt;
  key_t       key_r, key_nxt;
  logic       empty_r, empty_nxt;

  logic       key_le;
  cnt_t       span;
  logic [CNT_W:0] sum;
  cnt_t       mid;
  logic       eq;

  function automatic cnt_t mid_of(input cnt_t h, input cnt_t l);
    logic [CNT_W:0] s;
    s = {1'b0, h} + {1'b0, l};
    return s[CNT_W:1];
  endfunction

  assign key_le = (key_r <= rd_data);
  assign eq     = (rd_data == key_r);
  assign span   = hi_nxt - lo_nxt;
  assign sum    = {1'b0, hi_nxt} + {1'b0, lo_nxt};
  assign mid    = sum[CNT_W:1];

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    key_nxt    = key_r;
    empty_nxt  = empty_r;
    rd_req.en  = 1'b0;
    rd_req.addr = '0;
    res_valid  = 1'b0;
    res.found  = 1'b0;
    res.pos    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = key;
          lo_nxt    = '0;
          hi_nxt    = n_used;
          empty_nxt = (n_used == '0);
        end
      end
      S_PROBE: begin
        if (key_le) begin
          hi_nxt = mid_of(hi_r, lo_r);
        end else begin
          lo_nxt = mid_of(hi_r, lo_r);
        end
      end
      S_FINAL: begin
        res_valid = 1'b1;
        res.found = !empty_r && eq;
        res.pos   = res.found ? POS_W'(hi_r - cnt_t'(1)) : '0;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // issue the next probe or the final read from the updated range
    if ((state_r == S_IDLE && start) || state_r == S_PROBE) begin
      if (span > cnt_t'(1)) begin
        rd_req.en   = 1'b1;
        rd_req.addr = ADDR_W'(mid - cnt_t'(1));
        state_nxt   = S_PROBE;
      end else begin
        rd_req.en   = !empty_nxt;
        rd_req.addr = ADDR_W'(hi_nxt - cnt_t'(1));
        state_nxt   = S_FINAL;
      end
    end
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    key_r   <= key_nxt;
    empty_r <= empty_nxt;
  end

endmodule

// ----- design/sorted_table_binary_search.sv -----
// Top level of the sorted key table with binary search lookup.
// Usage:
//   in_*  : one item per handshake. opcode 0 stores key_value at entry_index
//           (indexes beyond the table are dropped) and gives no result;
//           opcode 1 looks key_value up among the first entry_count entries.
//   out_* : one item per lookup: found, and match_position (0 if not found).
//   cfg_* : entry_count is written whenever cfg_wr_en is high; values above
//           the table depth are clamped. Write it only while the block idles.
// Flow:
//   in_ready stays high across writes, so writes run back to back.
//   A lookup makes up to ceil(log2(entry_count)) probes on the single table
//   read port, then, unless the table is empty, a final read of the candidate
//   entry for the equality compare. in_ready is low while a lookup runs.
// Stalls: the result sits in an output register; the next item is accepted
//   while it waits. A further lookup holds its result until the register
//   frees.
// Reset: entry_count clears to 0 and no result is pending; the table holds
//   undefined contents until written.
`timescale 1ns / 1ps
module sorted_table_binary_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [stbs_pkg::IN_IDX_W-1:0] in_entry_index,
  input  logic [stbs_pkg::IN_KEY_W-1:0] in_key_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [stbs_pkg::POS_W-1:0]    out_match_position,
  input  logic                          cfg_wr_en,
  input  logic [stbs_pkg::CFG_W-1:0]    cfg_wr_data
);
  import stbs_pkg::*;

  logic [CFG_W-1:0] count_r;
  cnt_t             n_used;
  logic             search_idle;
  logic             in_acc;
  logic             start;
  logic             wr_en;
  key_t             key_in;
  rd_req_t          rd_req;
  key_t             rd_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;

  assign in_ready = search_idle;
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && (in_opcode == OP_LOOKUP);
  assign key_in   = KEY_WIDTH'(in_key_value);
  assign wr_en    = in_acc && (in_opcode == OP_WRITE)
                    && (32'(in_entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    if (32'(count_r) > 32'(TABLE_DEPTH)) begin
      n_used = CNT_W'(TABLE_DEPTH);
    end else begin
      n_used = CNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  stbs_key_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(in_entry_index)),
    .wr_data (key_in),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  stbs_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .key       (key_in),
    .n_used    (n_used),
    .idle      (search_idle),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_r.found;
  assign out_match_position = out_r.pos;

  a_pos_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_position == '0)
    else $error("match position not zero on a miss");

  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("ready high right after a lookup was accepted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> !(out_valid && $past(res_valid) && !$stable(out_r)))
    else $error("pending result overwritten while stalled");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    start && n_used == '0 |-> !rd_req.en)
    else $error("table read issued for an empty table");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sorted key table with binary search lookup.
`timescale 1ns / 1ps
module testbench;
  import stbs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int GUARD_CYCLES = 20;

  typedef struct packed {
    logic                opcode;
    logic [IN_IDX_W-1:0] entry_index;
    logic [IN_KEY_W-1:0] key_value;
  } table_op_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_opcode = OP_WRITE;
  logic [IN_IDX_W-1:0] in_entry_index = '0;
  logic [IN_KEY_W-1:0] in_key_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic [POS_W-1:0]    out_match_position;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  // Stimulus side: items waiting for the driver and the keys as planned
  table_op_t           pending_items[$];
  table_op_t           next_op;
  logic [IN_KEY_W-1:0] plan_keys[TABLE_DEPTH];
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  // Predictor side: table and entry count as the block should hold them
  logic [KEY_WIDTH-1:0] table_copy[TABLE_DEPTH];
  logic [CFG_W-1:0]     entries_in_use = '0;
  result_t              lookup_answers[$];
  result_t              due;
  int                   failures = 0;

  logic hold_arm = 1'b0;
  logic hold_used;
  int   hold_left;
  int   cycles_run;

  sorted_table_binary_search u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_key_value       (in_key_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Lower-bound search over the entries in use; candidate entry is hi - 1
  function automatic result_t lower_bound_match(input logic [KEY_WIDTH-1:0] key);
    result_t     r;
    int unsigned n, lo, hi, mid;
    r = '0;
    n = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : entries_in_use;
    if (n == 0) return r;
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if (key <= table_copy[ADDR_W'(mid - 1)]) hi = mid;
      else lo = mid;
    end
    if (table_copy[ADDR_W'(hi - 1)] == key) begin
      r.found = 1'b1;
      r.pos = POS_W'(hi - 1);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_opcode == OP_WRITE) begin
          if (in_entry_index < TABLE_DEPTH) table_copy[in_entry_index] = in_key_value;
        end else begin
          lookup_answers.push_back(lower_bound_match(in_key_value));
        end
      end
      // Hold the item until it is taken, then offer the next one or idle
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = pending_items.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_op.opcode;
          in_entry_index <= next_op.entry_index;
          in_key_value <= next_op.key_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_answers.size() == 0) begin
          $error("unexpected result: found %0d, match_position %0d",
                 out_found, out_match_position);
          failures++;
        end else begin
          due = lookup_answers.pop_front();
          if (out_found !== due.found) begin
            $error("found: expected %0d, got %0d", due.found, out_found);
            failures++;
          end
          if (out_match_position !== due.pos) begin
            $error("match_position: expected %0d, got %0d", due.pos, out_match_position);
            failures++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One long receiver hold-off so that the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  task automatic add_item(input logic op, input logic [IN_IDX_W-1:0] idx,
                          input logic [IN_KEY_W-1:0] key);
    table_op_t item;
    item.opcode = op;
    item.entry_index = idx;
    item.key_value = key;
    if (op == OP_WRITE) plan_keys[idx] = key;
    pending_items.push_back(item);
  endtask

  // Wait until everything queued is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || lookup_answers.size() != 0);
    repeat (GUARD_CYCLES) @(negedge clk);
  endtask

  task automatic write_entry_count(input logic [CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    entries_in_use = value;
    @(negedge clk);
  endtask

  // Write the whole table in shuffled order with ascending keys, some repeated
  task automatic fill_table();
    int                  order[TABLE_DEPTH];
    logic [IN_KEY_W-1:0] fill_keys[TABLE_DEPTH];
    int                  k, swap, t;
    for (k = 0; k < TABLE_DEPTH; k++) order[ADDR_W'(k)] = k;
    for (k = TABLE_DEPTH - 1; k > 0; k--) begin
      swap = $urandom_range(k);
      t = order[ADDR_W'(k)];
      order[ADDR_W'(k)] = order[ADDR_W'(swap)];
      order[ADDR_W'(swap)] = t;
    end
    fill_keys[0] = '0;
    for (k = 1; k < TABLE_DEPTH; k++)
      fill_keys[ADDR_W'(k)] = fill_keys[ADDR_W'(k - 1)] +
                     (($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4000000));
    fill_keys[TABLE_DEPTH - 1] = '1;
    for (k = 0; k < TABLE_DEPTH; k++)
      add_item(OP_WRITE, IN_IDX_W'(order[ADDR_W'(k)]),
               fill_keys[ADDR_W'(order[ADDR_W'(k)])]);
  endtask

  task automatic queue_random_item(input bit noisy);
    int unsigned         n, pick, j;
    logic [IN_KEY_W-1:0] lo, hi, key;
    longint unsigned     span;
    n = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : entries_in_use;
    pick = $urandom_range(99);
    j = $urandom_range(TABLE_DEPTH - 1);
    if (noisy && pick < 12) begin
      add_item(OP_WRITE, IN_IDX_W'(j), $urandom);
    end else if (pick < 22) begin
      // Rewrite an entry with a key that keeps the table in order where the neighbours allow
      lo = (j == 0) ? '0 : plan_keys[ADDR_W'(j - 1)];
      hi = (j == TABLE_DEPTH - 1) ? '1 : plan_keys[ADDR_W'(j + 1)];
      if (hi >= lo) begin
        span = {32'b0, hi} - lo + 1;
        key = lo + IN_KEY_W'({$urandom, $urandom} % span);
      end else begin
        key = $urandom;
      end
      add_item(OP_WRITE, IN_IDX_W'(j), key);
    end else begin
      if (n == 0) begin
        key = $urandom;
      end else begin
        j = $urandom_range(n - 1);
        if (pick < 60) key = plan_keys[ADDR_W'(j)];
        else if (pick < 75) key = plan_keys[ADDR_W'(j)] + 1;
        else if (pick < 85) key = plan_keys[ADDR_W'(j)] - 1;
        else if (pick < 90) key = '0;
        else if (pick < 95) key = '1;
        else key = $urandom;
      end
      add_item(OP_LOOKUP, IN_IDX_W'($urandom_range(TABLE_DEPTH - 1)), key);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count, input int send_pct,
                           input int recv_pct, input int items, input bit noisy);
    write_entry_count(count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (items) queue_random_item(noisy);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table answers not found whatever the key
    add_item(OP_LOOKUP, '1, '0);
    add_item(OP_LOOKUP, '0, '1);
    add_item(OP_WRITE, 0, '0);
    add_item(OP_WRITE, 1, 32'd7);
    add_item(OP_WRITE, 2, 32'd7);
    add_item(OP_WRITE, 3, '1);
    add_item(OP_WRITE, '1, 32'h8000_0000);

    // Four entries: duplicates resolve to the first, misses report position 0
    write_entry_count(11'd4);
    add_item(OP_LOOKUP, 0, '0);
    add_item(OP_LOOKUP, 0, 32'd7);
    add_item(OP_LOOKUP, 0, 32'd6);
    add_item(OP_LOOKUP, 0, 32'd8);
    add_item(OP_LOOKUP, 0, '1);
    add_item(OP_LOOKUP, 0, 32'hFFFF_FFFE);

    write_entry_count(11'd1);
    add_item(OP_LOOKUP, 0, '0);
    add_item(OP_LOOKUP, 0, 32'd1);

    send_idle_pct = 34;
    fill_table();

    // Each phase opens with the sender paused until every result is back
    run_phase('1, 0, 0, 80, 1'b0);
    run_phase(11'd1024, 74, 0, 90, 1'b0);
    run_phase(11'd1000, 0, 74, 90, 1'b0);
    run_phase(11'd1, 34, 34, 60, 1'b0);
    run_phase(11'd1024, 0, 0, 0, 1'b0);
    hold_arm = 1'b1;
    repeat (100) queue_random_item(1'b0);
    run_phase(CFG_W'($urandom_range(2, 1023)), 34, 34, 90, 1'b0);
    run_phase(CFG_W'($urandom_range(2, 1023)), 74, 0, 90, 1'b1);
    run_phase(11'd3, 0, 74, 60, 1'b0);

    wait_idle();
    if (failures == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
